FILE: rtl/ofs_pkg.sv
// ----------------------------------------------------------------------------
// ofs_pkg
// Shared types, codes and helpers for the operand-fetch sequencer.
// ----------------------------------------------------------------------------
package ofs_pkg;

    localparam int InDataW  = 40;   // 37 bits of fields, padded to 5 bytes
    localparam int OutDataW = 56;   // 50 bits of fields, padded to 7 bytes

    // Command kinds on the input stream (tuser)
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Result kinds on the output stream (tuser)
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    // Addressing modes
    localparam logic [4:0] MODE_NONE       = 5'd0;
    localparam logic [4:0] MODE_REG_D16    = 5'd1;
    localparam logic [4:0] MODE_REGADD_REG = 5'd2;
    localparam logic [4:0] MODE_REG        = 5'd3;
    localparam logic [4:0] MODE_REG_D8     = 5'd4;
    localparam logic [4:0] MODE_A16_REG    = 5'd5;
    localparam logic [4:0] MODE_REG_REG    = 5'd6;
    localparam logic [4:0] MODE_REG_REGADD = 5'd7;
    localparam logic [4:0] MODE_HLINC_REG  = 5'd8;
    localparam logic [4:0] MODE_REG_HLINC  = 5'd9;
    localparam logic [4:0] MODE_HLDEC_REG  = 5'd10;
    localparam logic [4:0] MODE_REGADD     = 5'd11;
    localparam logic [4:0] MODE_REGADD_D8  = 5'd12;
    localparam logic [4:0] MODE_REG_HLDEC  = 5'd13;
    localparam logic [4:0] MODE_D16        = 5'd14;
    localparam logic [4:0] MODE_D8         = 5'd15;
    localparam logic [4:0] MODE_A8_REG     = 5'd16;
    localparam logic [4:0] MODE_REG_A8     = 5'd17;
    localparam logic [4:0] MODE_HL_SPR8    = 5'd18;
    localparam logic [4:0] MODE_REG_A16    = 5'd19;

    // Register selectors
    localparam logic [3:0] SEL_C    = 4'd3;
    localparam logic [3:0] SEL_AF   = 4'd8;
    localparam logic [3:0] SEL_HL   = 4'd11;
    localparam logic [3:0] SEL_SP   = 4'd12;
    localparam logic [3:0] SEL_PC   = 4'd13;

    // Fetch steps
    localparam logic [1:0] STEP_IDLE = 2'd0;
    localparam logic [1:0] STEP_1    = 2'd1;
    localparam logic [1:0] STEP_2    = 2'd2;
    localparam logic [1:0] STEP_3    = 2'd3;

    localparam logic [15:0] HIGH_PAGE = 16'hFF00;

    typedef struct packed {
        logic        en;
        logic [3:0]  sel;
        logic [15:0] value;
    } wr_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] bus_address;
        logic [15:0] fetched_value;
        logic [15:0] dest_address;
        logic        dest_is_memory;
        logic        bad_mode;
    } res_t;

    // Value of selector sel once write w has landed, given its value before.
    function automatic logic [15:0] after_write(logic [3:0] sel, logic [15:0] old, wr_t w);
        logic [15:0] r;
        r = old;
        if (w.en && sel <= SEL_PC) begin
            if (w.sel == sel) begin
                r = (sel < SEL_AF) ? {8'h00, w.value[7:0]} : w.value;
            end else if (sel < SEL_AF && w.sel inside {[SEL_AF:SEL_HL]}
                         && w.sel[1:0] == sel[2:1]) begin
                r = sel[0] ? {8'h00, w.value[7:0]} : {8'h00, w.value[15:8]};
            end else if (sel inside {[SEL_AF:SEL_HL]} && w.sel < SEL_AF
                         && w.sel[2:1] == sel[1:0]) begin
                r = w.sel[0] ? {old[15:8], w.value[7:0]} : {w.value[7:0], old[7:0]};
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/cpu_operand_fetch_sequencer.sv
// ----------------------------------------------------------------------------
// cpu_operand_fetch_sequencer
// Operand fetch for an 8-bit CPU: register file, addressing-mode sequencing,
// bus read requests and operand completion on a pair of streams.
//
// Every input beat is a command: start a fetch, hand back a bus byte, or
// write a register. Each command yields at most one output beat: either a
// bus read request (tuser 0, address in bus_address) or a completed fetch
// (tuser 1) with the operand, the memory destination and a bad-mode flag.
// The block takes one beat per cycle while no output beat waits. A command
// accepted into the input register is executed in a single pass against
// the register file once the result slot is free or being drained, and its
// result is then loaded into the output register, which drives m_*. While
// an output beat waits, the execute stage stalls; an empty input register
// can still take one beat, after which s_tready stays low until m_tready
// returns.
// ----------------------------------------------------------------------------
module cpu_operand_fetch_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // addr_mode[4:0] first_reg[8:5] second_reg[12:9] bus_byte[20:13]
    // write_value[36:21], zero pad [39:37]
    input  logic [ofs_pkg::InDataW-1:0]   s_tdata,
    // opcode[1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // bus_address[15:0] fetched_value[31:16] dest_address[47:32]
    // dest_is_memory[48] bad_mode[49], zero pad [55:50]
    output logic [ofs_pkg::OutDataW-1:0]  m_tdata,
    // result_kind[0]
    output logic                          m_tuser
);
    import ofs_pkg::*;

    // input register
    logic               in_valid_reg;
    logic [1:0]         in_user_reg;
    logic [InDataW-1:0] in_data_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    res_t               out_res_reg;

    logic        exec_fire;
    wr_t         wr;
    res_t        res;
    logic        res_valid;
    logic [3:0]  pend_first, pend_second;
    logic [15:0] rd_in1, rd_in2, rd_pend1, rd_pend2, hl, sp, pc;

    // execute whenever an item is staged and the result slot is free or
    // being drained this cycle
    assign exec_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || exec_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_user_reg <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    ofs_regfile u_regfile (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (wr),
        .rd_sel_a (in_data_reg[8:5]),
        .rd_sel_b (in_data_reg[12:9]),
        .rd_sel_c (pend_first),
        .rd_sel_d (pend_second),
        .rd_a     (rd_in1),
        .rd_b     (rd_in2),
        .rd_c     (rd_pend1),
        .rd_d     (rd_pend2),
        .hl       (hl),
        .sp       (sp),
        .pc       (pc)
    );

    ofs_exec u_exec (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (exec_fire),
        .opcode      (in_user_reg),
        .addr_mode   (in_data_reg[4:0]),
        .first_reg   (in_data_reg[8:5]),
        .second_reg  (in_data_reg[12:9]),
        .bus_byte    (in_data_reg[20:13]),
        .write_value (in_data_reg[36:21]),
        .rd_in1      (rd_in1),
        .rd_in2      (rd_in2),
        .rd_pend1    (rd_pend1),
        .rd_pend2    (rd_pend2),
        .hl          (hl),
        .sp          (sp),
        .pc          (pc),
        .pend_first  (pend_first),
        .pend_second (pend_second),
        .wr          (wr),
        .res         (res),
        .res_valid   (res_valid)
    );

    // result register: loaded on execute, held while stalled
    always_comb begin
        if (exec_fire) begin
            out_valid_next = res_valid;
        end else begin
            out_valid_next = out_valid_reg && !m_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tdata  = {6'd0, out_res_reg.bad_mode, out_res_reg.dest_is_memory,
                       out_res_reg.dest_address, out_res_reg.fetched_value,
                       out_res_reg.bus_address};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_request_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_REQUEST |->
            out_res_reg.fetched_value == 16'd0 && out_res_reg.dest_address == 16'd0
            && !out_res_reg.dest_is_memory && !out_res_reg.bad_mode)
        else $error("read request carries completion fields");

    a_dest_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !out_res_reg.dest_is_memory |-> out_res_reg.dest_address == 16'd0)
        else $error("destination address without memory destination");

    a_bad_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_res_reg.bad_mode |->
            m_tuser == KIND_DONE && !out_res_reg.dest_is_memory)
        else $error("bad mode on a request or with memory destination");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire && res_valid |=> m_tvalid)
        else $error("executed result not presented");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a blocked result");

endmodule

FILE: rtl/ofs_regfile.sv
// ----------------------------------------------------------------------------
// ofs_regfile
// Byte registers A F B C D E H L, SP and PC; four selectable read ports,
// one write port, direct HL/SP/PC taps.
// ----------------------------------------------------------------------------
module ofs_regfile (
    input  logic          aclk,
    input  logic          aresetn,
    input  ofs_pkg::wr_t  wr,
    input  logic [3:0]    rd_sel_a,
    input  logic [3:0]    rd_sel_b,
    input  logic [3:0]    rd_sel_c,
    input  logic [3:0]    rd_sel_d,
    output logic [15:0]   rd_a,
    output logic [15:0]   rd_b,
    output logic [15:0]   rd_c,
    output logic [15:0]   rd_d,
    output logic [15:0]   hl,
    output logic [15:0]   sp,
    output logic [15:0]   pc
);
    import ofs_pkg::*;

    logic [7:0]  byte_reg [8];
    logic [15:0] sp_reg;
    logic [15:0] pc_reg;

    function automatic logic [15:0] rd(logic [3:0] sel);
        logic [15:0] r;
        r = '0;
        if (sel < SEL_AF) begin
            r = {8'h00, byte_reg[sel[2:0]]};
        end else if (sel <= SEL_HL) begin
            r = {byte_reg[{sel[1:0], 1'b0}], byte_reg[{sel[1:0], 1'b1}]};
        end else if (sel == SEL_SP) begin
            r = sp_reg;
        end else if (sel == SEL_PC) begin
            r = pc_reg;
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                byte_reg[i] <= '0;
            end
            sp_reg <= '0;
            pc_reg <= '0;
        end else if (wr.en) begin
            if (wr.sel < SEL_AF) begin
                byte_reg[wr.sel[2:0]] <= wr.value[7:0];
            end else if (wr.sel <= SEL_HL) begin
                byte_reg[{wr.sel[1:0], 1'b0}] <= wr.value[15:8];
                byte_reg[{wr.sel[1:0], 1'b1}] <= wr.value[7:0];
            end else if (wr.sel == SEL_SP) begin
                sp_reg <= wr.value;
            end else if (wr.sel == SEL_PC) begin
                pc_reg <= wr.value;
            end
        end
    end

    assign rd_a = rd(rd_sel_a);
    assign rd_b = rd(rd_sel_b);
    assign rd_c = rd(rd_sel_c);
    assign rd_d = rd(rd_sel_d);
    assign hl   = {byte_reg[6], byte_reg[7]};
    assign sp   = sp_reg;
    assign pc   = pc_reg;

endmodule

FILE: rtl/ofs_exec.sv
// ----------------------------------------------------------------------------
// ofs_exec
// Fetch sequencing: step state, pending mode and selectors, latches, and the
// combinational step logic: at most one register write and at most one result.
// ----------------------------------------------------------------------------
module ofs_exec (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fire,
    input  logic [1:0]    opcode,
    input  logic [4:0]    addr_mode,
    input  logic [3:0]    first_reg,
    input  logic [3:0]    second_reg,
    input  logic [7:0]    bus_byte,
    input  logic [15:0]   write_value,
    input  logic [15:0]   rd_in1,
    input  logic [15:0]   rd_in2,
    input  logic [15:0]   rd_pend1,
    input  logic [15:0]   rd_pend2,
    input  logic [15:0]   hl,
    input  logic [15:0]   sp,
    input  logic [15:0]   pc,
    output logic [3:0]    pend_first,
    output logic [3:0]    pend_second,
    output ofs_pkg::wr_t  wr,
    output ofs_pkg::res_t res,
    output logic          res_valid
);
    import ofs_pkg::*;

    logic [1:0]  step_reg,  step_next;
    logic [4:0]  mode_reg,  mode_next;
    logic [7:0]  regs_reg,  regs_next;   // second selector high, first low
    logic [7:0]  low_reg,   low_next;
    logic [15:0] work_reg,  work_next;
    logic [15:0] held_reg,  held_next;

    logic [15:0] pc_inc;
    logic [15:0] hl_step;
    logic [15:0] word;
    wr_t         pc_wr;

    assign pend_first  = regs_reg[3:0];
    assign pend_second = regs_reg[7:4];
    assign pc_inc      = pc + 16'd1;
    assign word        = {bus_byte, low_reg};
    assign pc_wr       = '{en: 1'b1, sel: SEL_PC, value: pc_inc};

    always_comb begin
        step_next = step_reg;
        mode_next = mode_reg;
        regs_next = regs_reg;
        low_next  = low_reg;
        work_next = work_reg;
        held_next = held_reg;
        wr        = '0;
        res       = '0;
        res_valid = 1'b0;
        hl_step   = hl;

        if (fire) begin
            case (opcode)
                OP_START: begin
                    mode_next = addr_mode;
                    regs_next = {second_reg, first_reg};
                    res_valid = 1'b1;
                    res.kind  = KIND_DONE;
                    step_next = STEP_IDLE;
                    case (addr_mode)
                        MODE_NONE: begin
                            res.fetched_value = held_reg;
                        end
                        MODE_REG_D16, MODE_A16_REG, MODE_D16, MODE_REG_A16,
                        MODE_REG_D8, MODE_REGADD_D8, MODE_D8, MODE_A8_REG,
                        MODE_REG_A8, MODE_HL_SPR8: begin
                            res.kind        = KIND_REQUEST;
                            res.bus_address = pc;
                            step_next       = STEP_1;
                        end
                        MODE_REGADD_REG: begin
                            res.fetched_value  = rd_in2;
                            res.dest_address   = (first_reg == SEL_C) ? (rd_in1 | HIGH_PAGE)
                                                                       : rd_in1;
                            res.dest_is_memory = 1'b1;
                        end
                        MODE_REG: begin
                            res.fetched_value = rd_in1;
                        end
                        MODE_REG_REG: begin
                            res.fetched_value = rd_in2;
                        end
                        MODE_REG_REGADD: begin
                            work_next       = (second_reg == SEL_C) ? (rd_in2 | HIGH_PAGE)
                                                                    : rd_in2;
                            res.kind        = KIND_REQUEST;
                            res.bus_address = work_next;
                            step_next       = STEP_1;
                        end
                        MODE_HLINC_REG, MODE_HLDEC_REG: begin
                            hl_step = (addr_mode == MODE_HLINC_REG) ? hl + 16'd1 : hl - 16'd1;
                            wr      = '{en: 1'b1, sel: SEL_HL, value: hl_step};
                            // source is read after HL has moved
                            res.fetched_value  = after_write(second_reg, rd_in2, wr);
                            res.dest_address   = hl;
                            res.dest_is_memory = 1'b1;
                        end
                        MODE_REG_HLINC, MODE_REG_HLDEC: begin
                            work_next       = hl;
                            res.kind        = KIND_REQUEST;
                            res.bus_address = hl;
                            step_next       = STEP_1;
                        end
                        MODE_REGADD: begin
                            work_next       = rd_in1;
                            res.kind        = KIND_REQUEST;
                            res.bus_address = rd_in1;
                            step_next       = STEP_1;
                        end
                        default: begin
                            res.fetched_value = held_reg;
                            res.bad_mode      = 1'b1;
                        end
                    endcase
                end

                OP_BYTE: begin
                    if (step_reg != STEP_IDLE) begin
                        res_valid = 1'b1;
                        res.kind  = KIND_DONE;
                        step_next = STEP_IDLE;
                        res.fetched_value = {8'h00, bus_byte};
                        case (mode_reg)
                            MODE_REG_D16, MODE_A16_REG, MODE_D16, MODE_REG_A16: begin
                                if (step_reg == STEP_1) begin
                                    low_next        = bus_byte;
                                    wr              = pc_wr;
                                    res.kind        = KIND_REQUEST;
                                    res.fetched_value = '0;
                                    res.bus_address = pc_inc;
                                    step_next       = STEP_2;
                                end else if (step_reg == STEP_2) begin
                                    wr = pc_wr;
                                    if (mode_reg == MODE_A16_REG) begin
                                        res.fetched_value  = after_write(pend_second,
                                                                         rd_pend2, pc_wr);
                                        res.dest_address   = word;
                                        res.dest_is_memory = 1'b1;
                                    end else if (mode_reg == MODE_REG_A16) begin
                                        work_next         = word;
                                        res.kind          = KIND_REQUEST;
                                        res.fetched_value = '0;
                                        res.bus_address   = word;
                                        step_next         = STEP_3;
                                    end else begin
                                        res.fetched_value = word;
                                    end
                                end
                            end
                            MODE_REG_D8, MODE_D8: begin
                                wr = pc_wr;
                            end
                            MODE_REGADD_D8: begin
                                wr                 = pc_wr;
                                res.dest_address   = after_write(pend_first, rd_pend1, pc_wr);
                                res.dest_is_memory = 1'b1;
                            end
                            MODE_A8_REG: begin
                                wr                 = pc_wr;
                                res.fetched_value  = after_write(pend_second, rd_pend2, pc_wr);
                                res.dest_address   = HIGH_PAGE | {8'h00, bus_byte};
                                res.dest_is_memory = 1'b1;
                            end
                            MODE_REG_A8: begin
                                if (step_reg == STEP_1) begin
                                    wr                = pc_wr;
                                    work_next         = HIGH_PAGE | {8'h00, bus_byte};
                                    res.kind          = KIND_REQUEST;
                                    res.fetched_value = '0;
                                    res.bus_address   = work_next;
                                    step_next         = STEP_2;
                                end
                            end
                            MODE_HL_SPR8: begin
                                wr                = pc_wr;
                                res.fetched_value = sp + {{8{bus_byte[7]}}, bus_byte};
                            end
                            MODE_REG_REGADD: begin
                                res.fetched_value = {8'h00, bus_byte};
                            end
                            MODE_REG_HLINC, MODE_REG_HLDEC: begin
                                hl_step = (mode_reg == MODE_REG_HLINC) ? hl + 16'd1
                                                                       : hl - 16'd1;
                                wr      = '{en: 1'b1, sel: SEL_HL, value: hl_step};
                            end
                            MODE_REGADD: begin
                                res.dest_address   = work_reg;
                                res.dest_is_memory = 1'b1;
                            end
                            default: begin
                                res_valid = 1'b0;
                                res       = '0;
                            end
                        endcase
                    end
                end

                OP_WRITE: begin
                    wr = '{en: 1'b1, sel: first_reg, value: write_value};
                end

                default: begin
                end
            endcase

            if (res_valid && res.kind == KIND_DONE) begin
                held_next = res.fetched_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
            mode_reg <= '0;
            regs_reg <= '0;
            low_reg  <= '0;
            work_reg <= '0;
            held_reg <= '0;
        end else begin
            step_reg <= step_next;
            mode_reg <= mode_next;
            regs_reg <= regs_next;
            low_reg  <= low_next;
            work_reg <= work_next;
            held_reg <= held_next;
        end
    end

endmodule
